FILE: hdl/tmi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmi_pkg;

  localparam int unsigned MAP_ROWS_DEF = 23;
  localparam int unsigned MAP_COLS_DEF = 21;
  localparam int unsigned CAL_ROWS     = 23;
  localparam int unsigned CAL_COLS     = 21;
  localparam int unsigned CAL_RW       = $clog2(CAL_ROWS);
  localparam int unsigned CAL_CW       = $clog2(CAL_COLS);
  localparam int unsigned MAP_IDX_W    = 6;
  localparam int unsigned ENTRY_W      = 6;

  localparam logic [ENTRY_W-1:0] CAL_MAP [CAL_ROWS][CAL_COLS] = '{
    '{6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,
      6'd0,6'd0,6'd0,6'd1,6'd2},
    '{6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd0,6'd1,
      6'd2,6'd2,6'd3,6'd5,6'd8},
    '{6'd1,6'd1,6'd1,6'd1,6'd1,6'd1,6'd1,6'd1,6'd2,6'd2,6'd2,6'd3,6'd3,6'd3,6'd4,6'd4,
      6'd5,6'd6,6'd8,6'd10,6'd12},
    '{6'd2,6'd2,6'd2,6'd2,6'd3,6'd3,6'd3,6'd3,6'd4,6'd4,6'd4,6'd4,6'd4,6'd5,6'd5,6'd7,
      6'd9,6'd10,6'd12,6'd12,6'd13},
    '{6'd3,6'd3,6'd3,6'd3,6'd4,6'd4,6'd4,6'd4,6'd4,6'd5,6'd5,6'd5,6'd6,6'd7,6'd8,6'd10,
      6'd12,6'd12,6'd13,6'd14,6'd15},
    '{6'd3,6'd3,6'd4,6'd4,6'd5,6'd5,6'd5,6'd5,6'd6,6'd6,6'd7,6'd8,6'd9,6'd10,6'd12,6'd12,
      6'd13,6'd13,6'd14,6'd15,6'd16},
    '{6'd4,6'd4,6'd4,6'd5,6'd5,6'd5,6'd6,6'd6,6'd7,6'd8,6'd9,6'd10,6'd11,6'd12,6'd12,6'd13,
      6'd14,6'd14,6'd15,6'd16,6'd17},
    '{6'd5,6'd5,6'd5,6'd5,6'd6,6'd6,6'd7,6'd7,6'd9,6'd9,6'd11,6'd11,6'd12,6'd13,6'd13,6'd14,
      6'd15,6'd16,6'd17,6'd18,6'd19},
    '{6'd6,6'd6,6'd7,6'd7,6'd8,6'd8,6'd9,6'd9,6'd11,6'd11,6'd12,6'd12,6'd13,6'd14,6'd15,
      6'd16,6'd17,6'd17,6'd18,6'd19,6'd20},
    '{6'd7,6'd7,6'd7,6'd8,6'd8,6'd9,6'd11,6'd11,6'd12,6'd12,6'd13,6'd14,6'd14,6'd15,6'd16,
      6'd17,6'd18,6'd19,6'd20,6'd21,6'd22},
    '{6'd8,6'd8,6'd8,6'd9,6'd11,6'd11,6'd13,6'd13,6'd14,6'd14,6'd14,6'd15,6'd16,6'd17,6'd17,
      6'd18,6'd19,6'd21,6'd21,6'd22,6'd23},
    '{6'd9,6'd9,6'd11,6'd11,6'd12,6'd12,6'd15,6'd15,6'd15,6'd15,6'd15,6'd16,6'd17,6'd18,
      6'd19,6'd20,6'd21,6'd22,6'd23,6'd23,6'd24},
    '{6'd11,6'd11,6'd12,6'd12,6'd13,6'd15,6'd17,6'd17,6'd17,6'd17,6'd17,6'd18,6'd18,6'd20,
      6'd21,6'd22,6'd22,6'd23,6'd24,6'd25,6'd25},
    '{6'd12,6'd12,6'd13,6'd13,6'd14,6'd16,6'd19,6'd19,6'd19,6'd19,6'd19,6'd19,6'd20,6'd21,
      6'd22,6'd23,6'd24,6'd24,6'd25,6'd26,6'd26},
    '{6'd12,6'd13,6'd13,6'd14,6'd15,6'd17,6'd20,6'd20,6'd20,6'd20,6'd20,6'd21,6'd22,6'd23,
      6'd23,6'd24,6'd25,6'd25,6'd26,6'd27,6'd27},
    '{6'd13,6'd14,6'd14,6'd15,6'd16,6'd18,6'd21,6'd21,6'd22,6'd22,6'd23,6'd23,6'd23,6'd24,
      6'd24,6'd25,6'd26,6'd27,6'd27,6'd28,6'd29},
    '{6'd14,6'd15,6'd16,6'd17,6'd17,6'd19,6'd22,6'd22,6'd22,6'd22,6'd23,6'd23,6'd24,6'd25,
      6'd26,6'd26,6'd27,6'd28,6'd28,6'd29,6'd30},
    '{6'd15,6'd16,6'd17,6'd18,6'd18,6'd20,6'd23,6'd23,6'd23,6'd23,6'd24,6'd25,6'd25,6'd26,
      6'd27,6'd27,6'd28,6'd29,6'd29,6'd30,6'd31},
    '{6'd16,6'd17,6'd18,6'd19,6'd19,6'd21,6'd24,6'd24,6'd24,6'd24,6'd25,6'd26,6'd26,6'd27,
      6'd28,6'd28,6'd29,6'd30,6'd30,6'd31,6'd32},
    '{6'd18,6'd18,6'd19,6'd20,6'd21,6'd23,6'd25,6'd25,6'd25,6'd25,6'd26,6'd27,6'd27,6'd28,
      6'd29,6'd30,6'd30,6'd31,6'd32,6'd32,6'd33},
    '{6'd19,6'd19,6'd20,6'd22,6'd22,6'd24,6'd26,6'd25,6'd26,6'd26,6'd27,6'd28,6'd29,6'd29,
      6'd30,6'd31,6'd31,6'd32,6'd33,6'd33,6'd34},
    '{6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,6'd27,6'd27,6'd28,6'd28,6'd29,6'd29,6'd30,6'd31,
      6'd30,6'd32,6'd33,6'd32,6'd34,6'd35,6'd34},
    '{6'd22,6'd23,6'd23,6'd23,6'd24,6'd26,6'd28,6'd29,6'd30,6'd30,6'd31,6'd31,6'd31,6'd32,
      6'd32,6'd32,6'd33,6'd34,6'd34,6'd35,6'd36}
  };

  function automatic logic [ENTRY_W-1:0] map_entry(input logic [MAP_IDX_W-1:0] row,
                                                   input logic [MAP_IDX_W-1:0] col);
    logic [ENTRY_W-1:0] val;
    val = '0;
    if (row < MAP_IDX_W'(CAL_ROWS) && col < MAP_IDX_W'(CAL_COLS)) begin
      val = CAL_MAP[row[CAL_RW-1:0]][col[CAL_CW-1:0]];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tmi_map_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module tmi_map_rom import tmi_pkg::*; #(
  parameter int unsigned MapRows = MAP_ROWS_DEF,
  parameter int unsigned MapCols = MAP_COLS_DEF,
  localparam int unsigned RowW   = $clog2(MapRows),
  localparam int unsigned ColW   = $clog2(MapCols)
) (
  input  wire logic               clk_i,
  input  wire logic [RowW-1:0]    row_a_i,
  input  wire logic [ColW-1:0]    col_a_i,
  input  wire logic [RowW-1:0]    row_b_i,
  input  wire logic [ColW-1:0]    col_b_i,
  output logic      [ENTRY_W-1:0] data_a_o,
  output logic      [ENTRY_W-1:0] data_b_o
);

  logic [ENTRY_W-1:0] data_a_q;
  logic [ENTRY_W-1:0] data_b_q;

  always_ff @(posedge clk_i) begin
    data_a_q <= map_entry(MAP_IDX_W'(row_a_i), MAP_IDX_W'(col_a_i));
    data_b_q <= map_entry(MAP_IDX_W'(row_b_i), MAP_IDX_W'(col_b_i));
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

`default_nettype wire

FILE: hdl/throttle_map_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake           word
// command   in   start_i & !busy_o   speed_i, force_req_i
// result    out  done_o              throttle_o
//
// One word accepted per cycle; its valid bit passes v1_q, v2_q, v3_q, v4_q and done_q to done_o.
// The data path runs through the divide-by-3200 multiply, the two-port calibration ROM read,
// the blend multiply, the divide-by-100 multiply and the output register.
// busy_o stays low; no clearing pass, the map is fixed.
// Reset clears only the valid pipeline. Each result shows for one cycle on done_o.

module throttle_map_interpolator import tmi_pkg::*; #(
  parameter int unsigned MapRows = MAP_ROWS_DEF,
  parameter int unsigned MapCols = MAP_COLS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic        [15:0] speed_i,
  input  wire logic signed [19:0] force_req_i,
  output logic                    done_o,
  output logic signed      [15:0] throttle_o
);

  localparam int unsigned RowW = $clog2(MapRows);
  localparam int unsigned ColW = $clog2(MapCols);

  logic accept;
  assign accept = start_i & ~busy_o;
  assign busy_o = 1'b0;

  // stage 0: |force| / 128 times reciprocal of 25
  logic        neg_d;
  logic [19:0] abs_d;
  logic [25:0] prod1_d;

  always_comb begin
    neg_d   = force_req_i[19];
    abs_d   = neg_d ? 20'(-force_req_i) : 20'(force_req_i);
    prod1_d = 26'(abs_d[19:7]) * 26'd5243;
  end

  logic        v1_q;
  logic        neg1_q;
  logic        low1_q;
  logic [19:0] abs1_q;
  logic [25:0] prod1_q;
  logic [15:0] spd1_q;

  always_ff @(posedge clk_i) begin
    neg1_q  <= neg_d;
    low1_q  <= force_req_i <= -20'sd6400;
    abs1_q  <= abs_d;
    prod1_q <= prod1_d;
    spd1_q  <= speed_i;
  end

  // stage 1: quotient, remainder, map indexes, weight
  logic [7:0]         qabs;
  logic [19:0]        qmul;
  logic [11:0]        rabs;
  logic signed [9:0]  qsgn;
  logic signed [9:0]  rsum;
  logic signed [12:0] rsgn;
  logic [6:0]         col7;
  logic [RowW-1:0]    row_d;
  logic [ColW-1:0]    col_d;
  logic [14:0]        s25;
  logic signed [15:0] t_d;

  always_comb begin
    qabs = prod1_q[24:17];
    qmul = 20'({qabs, 11'b0}) + 20'({qabs, 10'b0}) + 20'({qabs, 7'b0});
    rabs = 12'(abs1_q - qmul);
    qsgn = neg1_q ? -$signed({2'b00, qabs}) : $signed({2'b00, qabs});
    rsgn = neg1_q ? -$signed({1'b0, rabs}) : $signed({1'b0, rabs});
    rsum = qsgn + 10'sd2;
    if (low1_q || rsum < 10'sd0) begin
      row_d = '0;
    end else if (rsum > $signed(10'(MapRows - 2))) begin
      row_d = RowW'(MapRows - 2);
    end else begin
      row_d = RowW'(rsum);
    end
    col7 = spd1_q[15:9];
    if (col7 > 7'(MapCols - 2)) begin
      col_d = ColW'(MapCols - 2);
    end else begin
      col_d = ColW'(col7);
    end
    s25 = 15'(spd1_q[8:0]) * 15'd25;
    t_d = $signed({1'b0, s25}) + $signed({rsgn[12], rsgn, 2'b00});
  end

  logic [ENTRY_W-1:0] m00;
  logic [ENTRY_W-1:0] m11;

  tmi_map_rom #(
    .MapRows (MapRows),
    .MapCols (MapCols)
  ) u_map_rom (
    .clk_i    (clk_i),
    .row_a_i  (row_d),
    .col_a_i  (col_d),
    .row_b_i  (RowW'(row_d + RowW'(1))),
    .col_b_i  (ColW'(col_d + ColW'(1))),
    .data_a_o (m00),
    .data_b_o (m11)
  );

  logic               v2_q;
  logic signed [15:0] t2_q;

  always_ff @(posedge clk_i) begin
    t2_q <= t_d;
  end

  // stage 2: blend numerator
  logic signed [6:0]  diff;
  logic signed [22:0] prod3;
  logic [20:0]        base;
  logic signed [22:0] num_d;

  always_comb begin
    diff  = $signed({1'b0, m11}) - $signed({1'b0, m00});
    prod3 = 23'(diff) * 23'(t2_q);
    base  = 21'(m00) * 21'd25600;
    num_d = prod3 + $signed({2'b00, base});
  end

  logic               v3_q;
  logic signed [22:0] num3_q;

  always_ff @(posedge clk_i) begin
    num3_q <= num_d;
  end

  // stage 3: |num| / 4 times reciprocal of 25
  logic [21:0] nabs;
  logic [40:0] prod4_d;

  always_comb begin
    nabs    = num3_q[22] ? 22'(-num3_q) : 22'(num3_q);
    prod4_d = 41'(nabs[21:2]) * 41'd1342178;
  end

  logic        v4_q;
  logic        neg4_q;
  logic [40:0] prod4_q;

  always_ff @(posedge clk_i) begin
    neg4_q  <= num3_q[22];
    prod4_q <= prod4_d;
  end

  // stage 4: sign, saturate
  logic [15:0]        qa;
  logic signed [16:0] res;
  logic signed [15:0] thr_d;

  always_comb begin
    qa  = prod4_q[40:25];
    res = neg4_q ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
    if (res > 17'sd32767) begin
      thr_d = 16'sh7fff;
    end else if (res < -17'sd32768) begin
      thr_d = -16'sh8000;
    end else begin
      thr_d = 16'(res);
    end
  end

  logic               done_q;
  logic signed [15:0] throttle_q;

  always_ff @(posedge clk_i) begin
    throttle_q <= thr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= v4_q;
    end
  end

  assign done_o     = done_q;
  assign throttle_o = throttle_q;

endmodule

`default_nettype wire

FILE: hdl/tmi_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tmi_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o
);

  a_word_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##5 done_o)
    else $error("accepted word gave no result");

  a_done_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 5))
    else $error("result without accepted word");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

endmodule

bind throttle_map_interpolator tmi_checker u_tmi_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);

`default_nettype wire
